FILE: rtl/mwmd_pkg.sv
`timescale 1ns / 1ps

package mwmd_pkg;

  // Width and reset value of the wheel speed limit register.
  localparam int LIMIT_WIDTH = 15;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'h7FFF;

  localparam int NUM_WHEELS = 4;

  typedef enum logic [1:0] {
    WHEEL_ZERO  = 2'd0,
    WHEEL_ONE   = 2'd1,
    WHEEL_TWO   = 2'd2,
    WHEEL_THREE = 2'd3
  } wheel_idx_e;

endpackage

FILE: rtl/mecanum_wheel_mix_desaturate.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// config    wheel_speed_limit_we_i       wheel_speed_limit_i
// command   in_valid_i / in_ready_o      vel_forward_i, vel_sideways_i, vel_rotate_i
// wheels    out_valid_o / out_ready_i    wheel_zero_o .. wheel_three_o, was_scaled_o
//
// One command beat is taken every cycle while in_ready_o is high. A result passes
// through the mix, magnitude, peak and multiply stages, then one stage per
// quotient bit of the restoring divider (SPEED_WIDTH - 1), then the output register.
// Reset clears the valid bits and sets the limit to its maximum.
// A stall on the output freezes every stage at once; in_ready_o is low only while
// a result waits in the output register and out_ready_i is low.

module mecanum_wheel_mix_desaturate #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wheel_speed_limit_we_i,
  input  logic [mwmd_pkg::LIMIT_WIDTH-1:0]    wheel_speed_limit_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SPEED_WIDTH-1:0]       vel_forward_i,
  input  logic signed [SPEED_WIDTH-1:0]       vel_sideways_i,
  input  logic signed [SPEED_WIDTH-1:0]       vel_rotate_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SPEED_WIDTH-1:0]       wheel_zero_o,
  output logic signed [SPEED_WIDTH-1:0]       wheel_one_o,
  output logic signed [SPEED_WIDTH-1:0]       wheel_two_o,
  output logic signed [SPEED_WIDTH-1:0]       wheel_three_o,
  output logic                                was_scaled_o
);
  import mwmd_pkg::*;

  localparam int W  = SPEED_WIDTH;
  localparam int SW = W + 2;          // mixed sum
  localparam int MW = W + 1;          // magnitude and peak
  localparam int QW = W - 1;          // effective limit and quotient
  localparam int PW = MW + QW;        // product
  localparam int DS = QW;             // divider stages
  localparam int CW = (QW > LIMIT_WIDTH) ? QW : LIMIT_WIDTH;
  localparam int NW = NUM_WHEELS;

  // Limit register and its cap at the largest output value.
  logic [LIMIT_WIDTH-1:0] limit_q;
  logic [CW-1:0]          lim_ext, cap_ext;
  logic [QW-1:0]          lim_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (wheel_speed_limit_we_i) begin
      limit_q <= wheel_speed_limit_i;
    end
  end

  always_comb begin
    lim_ext = CW'(limit_q);
    cap_ext = CW'({QW{1'b1}});
    lim_eff = (lim_ext > cap_ext) ? QW'(cap_ext) : QW'(lim_ext);
  end

  // The whole pipeline moves together whenever the output register can take a beat.
  logic adv;
  logic out_valid_q;
  assign adv        = out_ready_i || !out_valid_q;
  assign in_ready_o = adv;

  // Stage 1: mix.
  logic signed [SW-1:0] fwd, side, rot;
  logic signed [SW-1:0] sum_d [NW];
  logic signed [SW-1:0] sum_q [NW];
  logic                 v1_q;

  always_comb begin
    fwd  = $signed({{2{vel_forward_i[W-1]}}, vel_forward_i});
    side = $signed({{2{vel_sideways_i[W-1]}}, vel_sideways_i});
    rot  = $signed({{2{vel_rotate_i[W-1]}}, vel_rotate_i});
    sum_d[WHEEL_ZERO]  = -fwd - side - rot;
    sum_d[WHEEL_ONE]   = -fwd + side - rot;
    sum_d[WHEEL_TWO]   = fwd + side - rot;
    sum_d[WHEEL_THREE] = fwd - side - rot;
  end

  // Stage 2: magnitude and sign.
  logic [MW-1:0] mag2_q [NW];
  logic [NW-1:0] neg2_q;
  logic          v2_q;

  // Stage 3: peak magnitude.
  logic [MW-1:0] mag3_q [NW];
  logic [NW-1:0] neg3_q;
  logic [MW-1:0] peak3_q;
  logic          v3_q;
  logic [MW-1:0] max01, max23, peak_d;

  always_comb begin
    max01  = (mag2_q[WHEEL_ZERO] > mag2_q[WHEEL_ONE]) ? mag2_q[WHEEL_ZERO]
                                                     : mag2_q[WHEEL_ONE];
    max23  = (mag2_q[WHEEL_TWO] > mag2_q[WHEEL_THREE]) ? mag2_q[WHEEL_TWO]
                                                      : mag2_q[WHEEL_THREE];
    peak_d = (max01 > max23) ? max01 : max23;
  end

  // Divider pipeline; index 0 is loaded by the multiply stage.
  logic [MW-1:0] d_rem_q  [DS+1][NW];
  logic [QW-1:0] d_low_q  [DS+1][NW];
  logic [QW-1:0] d_quo_q  [DS+1][NW];
  logic [MW-1:0] d_mag_q  [DS+1][NW];
  logic [NW-1:0] d_neg_q  [DS+1];
  logic [MW-1:0] d_peak_q [DS+1];
  logic          d_scl_q  [DS+1];
  logic          d_vld_q  [DS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      d_vld_q[0] <= 1'b0;
    end else if (adv) begin
      v1_q       <= in_valid_i;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      d_vld_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      peak3_q     <= peak_d;
      neg3_q      <= neg2_q;
      d_peak_q[0] <= peak3_q;
      d_neg_q[0]  <= neg3_q;
      d_scl_q[0]  <= peak3_q > MW'(lim_eff);
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_front
    logic [SW-1:0] abs_val;
    logic [PW-1:0] prod;

    assign abs_val = sum_q[j][SW-1] ? SW'(-sum_q[j]) : SW'(sum_q[j]);
    assign prod    = PW'(mag3_q[j]) * PW'(lim_eff);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sum_q[j]      <= sum_d[j];
        mag2_q[j]     <= abs_val[MW-1:0];
        neg2_q[j]     <= sum_q[j][SW-1];
        mag3_q[j]     <= mag2_q[j];
        d_rem_q[0][j] <= prod[PW-1:QW];
        d_low_q[0][j] <= prod[QW-1:0];
        d_quo_q[0][j] <= '0;
        d_mag_q[0][j] <= mag3_q[j];
      end
    end
  end

  // One quotient bit per stage: shift in the next product bit, subtract if it fits.
  for (genvar k = 0; k < DS; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        d_vld_q[k+1] <= d_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_neg_q[k+1]  <= d_neg_q[k];
        d_peak_q[k+1] <= d_peak_q[k];
        d_scl_q[k+1]  <= d_scl_q[k];
      end
    end

    for (genvar j = 0; j < NW; j++) begin : g_lane
      logic [MW:0] trial, diff;
      logic        take;

      assign trial = {d_rem_q[k][j], d_low_q[k][j][QW-1-k]};
      assign take  = trial >= {1'b0, d_peak_q[k]};
      assign diff  = trial - {1'b0, d_peak_q[k]};

      always_ff @(posedge clk_i) begin
        if (adv) begin
          d_rem_q[k+1][j] <= take ? diff[MW-1:0] : trial[MW-1:0];
          d_low_q[k+1][j] <= d_low_q[k][j];
          d_quo_q[k+1][j] <= {d_quo_q[k][j][QW-2:0], take};
          d_mag_q[k+1][j] <= d_mag_q[k][j];
        end
      end
    end
  end

  // Output register: pick the quotient or the unscaled magnitude, then restore the sign.
  logic signed [W-1:0] wheel_q [NW];
  logic                scaled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d_vld_q[DS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scaled_q <= d_scl_q[DS];
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_out
    logic [W-1:0] val;

    assign val = d_scl_q[DS] ? {1'b0, d_quo_q[DS][j]} : d_mag_q[DS][j][W-1:0];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        wheel_q[j] <= d_neg_q[DS][j] ? $signed(-val) : $signed(val);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wheel_zero_o  = wheel_q[WHEEL_ZERO];
  assign wheel_one_o   = wheel_q[WHEEL_ONE];
  assign wheel_two_o   = wheel_q[WHEEL_TWO];
  assign wheel_three_o = wheel_q[WHEEL_THREE];
  assign was_scaled_o  = scaled_q;

endmodule

FILE: tb/mecanum_wheel_mix_desaturate_test.sv
`timescale 1ns / 1ps

module mecanum_wheel_mix_desaturate_test;
  import mwmd_pkg::*;

  localparam int SPEED_WIDTH = 16;
  localparam int SPEED_MAX = 2 ** (SPEED_WIDTH - 1) - 1;
  localparam int SPEED_MIN = -SPEED_MAX - 1;
  // Mix, magnitude, peak, multiply, one stage per quotient bit, output register.
  localparam int PIPE_LATENCY = SPEED_WIDTH + 4;
  localparam int DRAIN_LIMIT = 5000;

  typedef logic signed [SPEED_WIDTH-1:0] speed_t;

  typedef struct packed {
    speed_t wheel_zero;
    speed_t wheel_one;
    speed_t wheel_two;
    speed_t wheel_three;
    logic   was_scaled;
  } wheels_t;

  typedef struct packed {
    speed_t  fwd;
    speed_t  side;
    speed_t  rot;
    bit      typed;
    wheels_t want;
  } command_row_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Rows with typed results are read straight off the mixing signs at the
  // reset limit; the rest go through the predictor.
  localparam command_row_t DIRECTED_ROWS [13] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{16'sd1, 16'sd0, 16'sd0, 1'b1, '{-16'sd1, -16'sd1, 16'sd1, 16'sd1, 1'b0}},
    '{16'sd0, 16'sd1, 16'sd0, 1'b1, '{-16'sd1, 16'sd1, 16'sd1, -16'sd1, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd1, 1'b1, '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0}},
    '{16'sh7FFF, 16'sd0, 16'sd0, 1'b1,
      '{-16'sd32767, -16'sd32767, 16'sd32767, 16'sd32767, 1'b0}},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b1,
      '{16'sd32767, 16'sd32767, -16'sd32767, -16'sd32767, 1'b1}},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b1,
      '{16'sd32767, -16'sd32767, -16'sd32767, 16'sd32767, 1'b1}},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b1,
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1}},
    '{16'sd0, 16'sd0, 16'sh7FFF, 1'b1,
      '{-16'sd32767, -16'sd32767, -16'sd32767, -16'sd32767, 1'b0}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
      '{16'sd32767, 16'sd10922, -16'sd10922, 16'sd10922, 1'b1}},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1,
      '{-16'sd32767, -16'sd10922, 16'sd10922, -16'sd10922, 1'b1}},
    '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh5555, 16'shAAAA, 16'sh0F0F, 1'b0, '0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   wheel_speed_limit_we_i;
  logic [LIMIT_WIDTH-1:0] wheel_speed_limit_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  speed_t                 vel_forward_i;
  speed_t                 vel_sideways_i;
  speed_t                 vel_rotate_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  speed_t                 wheel_zero_o;
  speed_t                 wheel_one_o;
  speed_t                 wheel_two_o;
  speed_t                 wheel_three_o;
  logic                   was_scaled_o;

  logic [LIMIT_WIDTH-1:0] speed_limit;
  wheels_t                pending_wheels [$];
  wheels_t                oldest_wheels;
  int unsigned            gap_pct;
  int unsigned            stall_pct;
  int                     mismatches;
  int                     results_seen;

  mecanum_wheel_mix_desaturate #(
    .SPEED_WIDTH(SPEED_WIDTH)
  ) DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .wheel_speed_limit_we_i(wheel_speed_limit_we_i),
    .wheel_speed_limit_i   (wheel_speed_limit_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .vel_forward_i         (vel_forward_i),
    .vel_sideways_i        (vel_sideways_i),
    .vel_rotate_i          (vel_rotate_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .wheel_zero_o          (wheel_zero_o),
    .wheel_one_o           (wheel_one_o),
    .wheel_two_o           (wheel_two_o),
    .wheel_three_o         (wheel_three_o),
    .was_scaled_o          (was_scaled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic wheels_t mix_and_desaturate(input speed_t fwd, input speed_t side,
                                                 input speed_t rot,
                                                 input logic [LIMIT_WIDTH-1:0] limit);
    longint  mix [NUM_WHEELS];
    longint  peak;
    longint  ceiling;
    longint  lim_eff;
    longint  mag;
    wheels_t res;
    ceiling = (longint'(1) << (SPEED_WIDTH - 1)) - 1;
    lim_eff = (longint'(limit) > ceiling) ? ceiling : longint'(limit);
    mix[WHEEL_ZERO]  = -longint'(fwd) - longint'(side) - longint'(rot);
    mix[WHEEL_ONE]   = -longint'(fwd) + longint'(side) - longint'(rot);
    mix[WHEEL_TWO]   = longint'(fwd) + longint'(side) - longint'(rot);
    mix[WHEEL_THREE] = longint'(fwd) - longint'(side) - longint'(rot);
    peak = 0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag = (mix[i] < 0) ? -mix[i] : mix[i];
      if (mag > peak) peak = mag;
    end
    res.was_scaled = (peak > lim_eff);
    // The divisor can never be zero here since peak exceeds a limit of at least zero.
    if (res.was_scaled) begin
      for (int i = 0; i < NUM_WHEELS; i++) mix[i] = (mix[i] * lim_eff) / peak;
    end
    res.wheel_zero  = speed_t'(mix[WHEEL_ZERO]);
    res.wheel_one   = speed_t'(mix[WHEEL_ONE]);
    res.wheel_two   = speed_t'(mix[WHEEL_TWO]);
    res.wheel_three = speed_t'(mix[WHEEL_THREE]);
    return res;
  endfunction

  function automatic speed_t random_speed(input int unsigned span);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return $urandom_range(1) ? speed_t'(SPEED_MAX) : speed_t'(SPEED_MIN);
    if (pick < 4) return speed_t'($urandom);
    return speed_t'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR %0t ns: %s", $time, msg);
  endtask

  task automatic check_wheel(input string name, input speed_t got, input speed_t want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_wheels.size() == 0) begin
        report_mismatch($sformatf("result beat with no command outstanding, wheel_zero %0d",
                                  wheel_zero_o));
      end else begin
        oldest_wheels = pending_wheels.pop_front();
        check_wheel("wheel_zero", wheel_zero_o, oldest_wheels.wheel_zero);
        check_wheel("wheel_one", wheel_one_o, oldest_wheels.wheel_one);
        check_wheel("wheel_two", wheel_two_o, oldest_wheels.wheel_two);
        check_wheel("wheel_three", wheel_three_o, oldest_wheels.wheel_three);
        if (was_scaled_o !== oldest_wheels.was_scaled)
          report_mismatch($sformatf("result %0d was_scaled got %b expected %b",
                                    results_seen, was_scaled_o, oldest_wheels.was_scaled));
      end
      results_seen++;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_command(input speed_t fwd, input speed_t side, input speed_t rot,
                              input bit typed, input wheels_t typed_want);
    wheels_t want;
    want = typed ? typed_want : mix_and_desaturate(fwd, side, rot, speed_limit);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    vel_forward_i  <= fwd;
    vel_sideways_i <= side;
    vel_rotate_i   <= rot;
    do @(posedge clk_i); while (!in_ready_o);
    pending_wheels.push_back(want);
  endtask

  // Drops valid and waits for every outstanding result, then lets the pipeline settle.
  task automatic wait_all_wheels();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_wheels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic write_speed_limit(input logic [LIMIT_WIDTH-1:0] value);
    @(negedge clk_i);
    wheel_speed_limit_we_i <= 1'b1;
    wheel_speed_limit_i    <= value;
    @(negedge clk_i);
    wheel_speed_limit_we_i <= 1'b0;
    speed_limit = value;
  endtask

  task automatic run_phase(input logic [LIMIT_WIDTH-1:0] limit, input idle_mode_e mode,
                           input int beats, input bit pause_midway);
    int unsigned span;
    wait_all_wheels();
    write_speed_limit(limit);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct = 76;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct = 76;
      end
      default: begin
        gap_pct = 11;
        stall_pct = 11;
      end
    endcase
    // Peak exactly at the limit stays unscaled; one step above it scales.
    send_command(speed_t'(limit), 16'sd0, 16'sd0, 1'b0, '0);
    send_command(16'sd0, 16'sd0, speed_t'(-(int'(limit) + 1)), 1'b0, '0);
    if (limit == 0) send_command(16'sd0, 16'sd0, 16'sd0, 1'b0, '0);
    for (int n = 0; n < beats; n++) begin
      if (pause_midway && n == beats / 2) wait_all_wheels();
      // Commands partly small enough to stay below the limit, with full range mixed in.
      if ($urandom_range(3) == 0 || limit < 3) span = (limit < 3) ? 1 : SPEED_MAX;
      else span = limit / 3;
      send_command(random_speed(span), random_speed(span), random_speed(span), 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    wheel_speed_limit_we_i = 1'b0;
    wheel_speed_limit_i    = '0;
    in_valid_i             = 1'b0;
    vel_forward_i          = '0;
    vel_sideways_i         = '0;
    vel_rotate_i           = '0;
    speed_limit            = LIMIT_RESET;
    gap_pct                = 0;
    stall_pct              = 0;
    mismatches             = 0;
    results_seen           = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[r])
      send_command(DIRECTED_ROWS[r].fwd, DIRECTED_ROWS[r].side, DIRECTED_ROWS[r].rot,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

    run_phase(LIMIT_RESET, IDLE_SENDER, 100, 1'b0);
    run_phase(15'd0, IDLE_NONE, 40, 1'b0);
    run_phase(15'd1, IDLE_RECEIVER, 80, 1'b0);
    run_phase(LIMIT_WIDTH'($urandom_range(32766, 2)), IDLE_BOTH, 120, 1'b0);
    run_phase(15'd1000, IDLE_NONE, 100, 1'b0);
    run_phase(LIMIT_WIDTH'($urandom_range(32766, 2)), IDLE_RECEIVER, 80, 1'b1);
    run_phase(15'd32767, IDLE_BOTH, 120, 1'b0);
    run_phase(15'd32766, IDLE_SENDER, 60, 1'b0);

    wait_all_wheels();
    if (pending_wheels.size() != 0)
      report_mismatch($sformatf("%0d wheel results never arrived", pending_wheels.size()));
    if (mismatches == 0) begin
      $display("mecanum_wheel_mix_desaturate_test passed");
    end else begin
      $display("mecanum_wheel_mix_desaturate_test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mecanum_wheel_mix_desaturate_test failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mwmd_pkg.sv
rtl/mecanum_wheel_mix_desaturate.sv
tb/mecanum_wheel_mix_desaturate_test.sv
